### hw/rtl/civil_date_to_epoch_seconds_assert.svh
// Assertion macros for the civil date to epoch seconds converter.
`ifndef CIVIL_DATE_TO_EPOCH_SECONDS_ASSERT_SVH
`define CIVIL_DATE_TO_EPOCH_SECONDS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CDES_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdes assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CDES_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdes assertion failed");

`endif

### hw/rtl/cdes_pkg.sv
// Shared types, constants, tables and microcode for the epoch seconds converter.
package cdes_pkg;

  typedef struct packed {
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } cdes_req_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic [2:0]  weekday;
    logic [4:0]  month_length;
    logic        leap_flag;
  } cdes_rsp_t;

  localparam int          FIRST_YEAR_INT   = 1970;
  localparam logic [11:0] FIRST_YEAR       = 12'(FIRST_YEAR_INT);
  localparam logic [4:0]  FIRST_YEAR_MOD25 = 5'(FIRST_YEAR_INT % 25);
  localparam logic [4:0]  LAST_MOD25       = 5'd24;
  localparam logic [8:0]  DAYS_COMMON      = 9'd365;
  localparam logic [8:0]  DAYS_LEAP        = 9'd366;
  localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN     = 6'd60;
  localparam logic [12:0] YEAR_OFFSET      = 13'd400;
  localparam logic [11:0] CYCLE_25         = 12'd25;
  localparam logic [12:0] WEEK_LEN         = 13'd7;
  // Reciprocals: x*R >> S equals x/D over the full range of x used here.
  localparam logic [11:0] RECIP_25         = 12'd2622;   // shift 16
  localparam logic [12:0] RECIP_100        = 13'd5243;   // shift 19
  localparam logic [13:0] RECIP_7          = 14'd9363;   // shift 16

  // Datapath operations.
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_INIT  = 4'd1;
  localparam logic [3:0] OP_LEAP  = 4'd2;
  localparam logic [3:0] OP_YEAR  = 4'd3;
  localparam logic [3:0] OP_MONTH = 4'd4;
  localparam logic [3:0] OP_SCALE = 4'd5;
  localparam logic [3:0] OP_HOUR  = 4'd6;
  localparam logic [3:0] OP_MIN   = 4'd7;
  localparam logic [3:0] OP_SEC   = 4'd8;
  localparam logic [3:0] OP_DONE  = 4'd9;

  // Sequencer jump kinds.
  localparam logic [2:0] J_NEXT = 3'd0;
  localparam logic [2:0] J_GOTO = 3'd1;
  localparam logic [2:0] J_WAIT = 3'd2;
  localparam logic [2:0] J_LOOP = 3'd3;
  localparam logic [2:0] J_HOLD = 3'd4;

  // Program steps.
  localparam logic [3:0] STEP_IDLE  = 4'd0;
  localparam logic [3:0] STEP_INIT  = 4'd1;
  localparam logic [3:0] STEP_LEAP  = 4'd2;
  localparam logic [3:0] STEP_YEAR  = 4'd3;
  localparam logic [3:0] STEP_MONTH = 4'd4;
  localparam logic [3:0] STEP_SCALE = 4'd5;
  localparam logic [3:0] STEP_HOUR  = 4'd6;
  localparam logic [3:0] STEP_MIN   = 4'd7;
  localparam logic [3:0] STEP_SEC   = 4'd8;
  localparam logic [3:0] STEP_DONE  = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] jmp;
    logic [3:0] target;
  } cdes_uword_t;

  typedef struct packed {
    logic       capture;
    logic [3:0] op;
  } cdes_ctrl_t;

  typedef struct packed {
    logic more;
    logic stall;
  } cdes_stat_t;

  // Month field to month index 0..11 with wrap modulo 12.
  function automatic logic [3:0] month_index(input logic [3:0] m);
    logic [3:0] r;
    unique case (m)
      4'd0:    r = 4'd11;
      4'd13:   r = 4'd0;
      4'd14:   r = 4'd1;
      4'd15:   r = 4'd2;
      default: r = m - 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] span_of_month(input logic [3:0] mi, input logic leap);
    logic [4:0] r;
    unique case (mi)
      4'd1:                           r = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:        r = 5'd30;
      default:                        r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] sakamoto_shift(input logic [3:0] mi);
    logic [2:0] r;
    unique case (mi)
      4'd0, 4'd4:   r = 3'd0;
      4'd1, 4'd5:   r = 3'd3;
      4'd2, 4'd10:  r = 3'd2;
      4'd3:         r = 3'd5;
      4'd6:         r = 3'd5;
      4'd7:         r = 3'd1;
      4'd8, 4'd11:  r = 3'd4;
      4'd9:         r = 3'd6;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  // Control store: one word per step.
  function automatic cdes_uword_t ucode(input logic [3:0] pc);
    cdes_uword_t w;
    unique case (pc)
      STEP_IDLE:  w = '{op: OP_NOP,   jmp: J_WAIT, target: STEP_IDLE};
      STEP_INIT:  w = '{op: OP_INIT,  jmp: J_NEXT, target: STEP_IDLE};
      STEP_LEAP:  w = '{op: OP_LEAP,  jmp: J_NEXT, target: STEP_IDLE};
      STEP_YEAR:  w = '{op: OP_YEAR,  jmp: J_LOOP, target: STEP_YEAR};
      STEP_MONTH: w = '{op: OP_MONTH, jmp: J_LOOP, target: STEP_MONTH};
      STEP_SCALE: w = '{op: OP_SCALE, jmp: J_NEXT, target: STEP_IDLE};
      STEP_HOUR:  w = '{op: OP_HOUR,  jmp: J_NEXT, target: STEP_IDLE};
      STEP_MIN:   w = '{op: OP_MIN,   jmp: J_NEXT, target: STEP_IDLE};
      STEP_SEC:   w = '{op: OP_SEC,   jmp: J_NEXT, target: STEP_IDLE};
      STEP_DONE:  w = '{op: OP_DONE,  jmp: J_HOLD, target: STEP_IDLE};
      default:    w = '{op: OP_NOP,   jmp: J_GOTO, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/cdes_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
module cdes_sequencer import cdes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  cdes_stat_t stat,
  output cdes_ctrl_t ctrl
);

  logic [3:0]  pc;
  logic [3:0]  pc_next;
  cdes_uword_t uw;

  assign uw           = ucode(pc);
  assign req_ready    = (uw.jmp == J_WAIT) && !rst;
  assign ctrl.capture = req_valid && req_ready;
  assign ctrl.op      = uw.op;

  always_comb begin
    unique case (uw.jmp)
      J_NEXT:  pc_next = pc + 4'd1;
      J_GOTO:  pc_next = uw.target;
      J_WAIT:  pc_next = ctrl.capture ? pc + 4'd1 : uw.target;
      J_LOOP:  pc_next = stat.more ? uw.target : pc + 4'd1;
      J_HOLD:  pc_next = stat.stall ? pc : uw.target;
      default: pc_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### hw/rtl/cdes_datapath.sv
// Datapath: day accumulator, weekday arithmetic and the result word register.
module cdes_datapath import cdes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cdes_req_t  req_data,
  input  cdes_ctrl_t ctrl,
  output cdes_stat_t stat,
  input  logic       rsp_ready,
  output logic       rsp_valid,
  output cdes_rsp_t  rsp_data
);

  logic [11:0] year;
  logic [3:0]  mi;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [31:0] acc;
  logic [11:0] y;
  logic [4:0]  y25;
  logic [3:0]  m;
  logic [7:0]  q25;
  logic        leap;
  logic [6:0]  hund;
  logic [12:0] wsum;
  logic [10:0] wq;
  logic [2:0]  wd;

  logic [12:0] wy;
  logic        year_more;
  logic        month_more;
  logic        y_leap;
  logic [8:0]  year_days;
  logic [23:0] prod25;
  logic [25:0] prod100;
  logic [26:0] prod7;
  logic [48:0] prod_day;
  logic [16:0] hour_secs;
  logic [11:0] min_secs;
  logic [12:0] wrem;
  logic        load_rsp;

  // Sakamoto year, shifted by 400 so it never goes negative.
  assign wy         = {1'b0, year} + YEAR_OFFSET - {12'd0, (mi < 4'd2)};
  assign year_more  = (y < year);
  assign month_more = (m < mi);
  // The mod-25 counter runs alongside y so no divider is needed in the loop.
  assign y_leap     = (y[1:0] == 2'd0) && ((y[3:0] == 4'd0) || (y25 != 5'd0));
  assign year_days  = y_leap ? DAYS_LEAP : DAYS_COMMON;
  assign prod25     = 24'(year) * 24'(RECIP_25);
  assign prod100    = 26'(wy) * 26'(RECIP_100);
  assign prod7      = 27'(wsum) * 27'(RECIP_7);
  assign prod_day   = 49'(acc) * 49'(SECS_PER_DAY);
  assign hour_secs  = 17'(hour) * 17'(SECS_PER_HOUR);
  assign min_secs   = 12'(minute) * 12'(SECS_PER_MIN);
  assign wrem       = wsum - ({2'd0, wq} * WEEK_LEN);

  assign stat.more  = (ctrl.op == OP_YEAR) ? year_more : month_more;
  assign stat.stall = rsp_valid && !rsp_ready;
  assign load_rsp   = (ctrl.op == OP_DONE) && !stat.stall;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      year   <= req_data.year_in;
      mi     <= month_index(req_data.month_in);
      day    <= req_data.day_in;
      hour   <= req_data.hour_in;
      minute <= req_data.minute_in;
      second <= req_data.second_in;
    end
    unique case (ctrl.op)
      OP_INIT: begin
        // A day of zero wraps the count below zero, as unsigned arithmetic does.
        acc <= {27'd0, day} - 32'd1;
        y   <= FIRST_YEAR;
        y25 <= FIRST_YEAR_MOD25;
        m   <= 4'd0;
        q25 <= prod25[23:16];
      end
      OP_LEAP: begin
        leap <= (year[1:0] == 2'd0) &&
                ((year[3:0] == 4'd0) || (year != ({4'd0, q25} * CYCLE_25)));
        hund <= prod100[25:19];
      end
      OP_YEAR: begin
        if (year_more) begin
          acc <= acc + {23'd0, year_days};
          y   <= y + 12'd1;
          y25 <= (y25 == LAST_MOD25) ? 5'd0 : y25 + 5'd1;
        end
      end
      OP_MONTH: begin
        if (month_more) begin
          acc <= acc + {27'd0, span_of_month(m, leap)};
          m   <= m + 4'd1;
        end
      end
      OP_SCALE: begin
        acc  <= prod_day[31:0];
        // Weekday sum of the year, month and day terms; wy/400 is (wy/100)/4.
        wsum <= wy + {2'd0, wy[12:2]} - {6'd0, hund} + {8'd0, hund[6:2]}
                + {10'd0, sakamoto_shift(mi)} + {8'd0, day};
      end
      OP_HOUR: begin
        acc <= acc + {15'd0, hour_secs};
        wq  <= prod7[26:16];
      end
      OP_MIN: begin
        acc <= acc + {20'd0, min_secs};
        wd  <= wrem[2:0];
      end
      OP_SEC: begin
        acc <= acc + {26'd0, second};
      end
      OP_DONE: begin
        if (load_rsp) begin
          rsp_data.epoch_seconds <= acc;
          rsp_data.weekday       <= wd;
          rsp_data.month_length  <= span_of_month(mi, leap);
          rsp_data.leap_flag     <= leap;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/civil_date_to_epoch_seconds.sv
// Top level of the civil date and time to epoch seconds converter.
// Each word runs from acceptance through init, leap, the year loop (one year per step from 1970),
// the month loop (one month per step), scale, hour, minute, second and done, one step per cycle
// except where done holds for a waiting result; the next word is accepted in the idle step after done.
// The result register lets a new word be accepted while the last result waits.
// Synchronous reset returns the step counter to idle and clears the result valid.
module civil_date_to_epoch_seconds import cdes_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  cdes_req_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output cdes_rsp_t rsp_data
);

`include "civil_date_to_epoch_seconds_assert.svh"

  cdes_ctrl_t ctrl;
  cdes_stat_t stat;

  cdes_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  cdes_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

  `CDES_ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)
  `CDES_ASSERT_IMP(a_rsp_from_done, clk, rst, $rose(rsp_valid), $past(ctrl.op == OP_DONE))
  `CDES_ASSERT_IMP(a_loop_not_ready, clk, rst, ctrl.op == OP_YEAR || ctrl.op == OP_MONTH, !req_ready)
  `CDES_ASSERT_IMP(a_feb29_leap, clk, rst, rsp_valid && (rsp_data.month_length == 5'd29), rsp_data.leap_flag)

endmodule
